// ===== rtl/sktc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktc_pkg
// Shared types, constants and the kana tile mapping for the Shift-JIS to
// tile code converter.
// ----------------------------------------------------------------------------
package sktc_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_CHAR = 2'd0,
        ST_END  = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  code;
        status_t     status;
        logic [15:0] error_pos;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } tile_t;

    localparam logic [7:0] LEAD_HIRA = 8'h82;
    localparam logic [7:0] LEAD_KATA = 8'h83;
    localparam logic [7:0] LEAD_YEN  = 8'h89;
    localparam logic [7:0] TRAIL_YEN = 8'h7e;
    localparam logic [7:0] TILE_YEN  = 8'h5f;

    // (v - 0x2e) / 3 for the ka-to-to range, q in 0..14
    function automatic logic [7:0] div3_small(input logic [7:0] q);
        logic [7:0] r;
        begin
            if (q < 8'd3)
                r = 8'd0;
            else if (q < 8'd6)
                r = 8'd1;
            else if (q < 8'd9)
                r = 8'd2;
            else if (q < 8'd12)
                r = 8'd3;
            else
                r = 8'd4;
            return r;
        end
    endfunction

    function automatic tile_t kana_tile(input logic [7:0] t, input logic hira);
        logic [7:0] base;
        logic [7:0] first;
        logic [7:0] tt;
        logic [7:0] v;
        logic [7:0] w;
        tile_t      res;
        begin
            base  = hira ? 8'hc0 : 8'h80;
            first = hira ? 8'h9f : 8'h40;
            tt    = (t >= 8'h7f && t <= 8'h96) ? t - 8'd1 : t;
            v     = tt - first;
            w     = 8'd0;
            res.valid = 1'b1;
            res.code  = 8'd0;
            if (v <= 8'h09) begin
                res.code = (v >> 1) + base + (v[0] ? 8'h11 : 8'h07);
            end
            else if (v >= 8'h0a && v <= 8'h28) begin
                if (v == 8'h22) begin
                    res.code = base + 8'h0f;
                end
                else begin
                    w = (v > 8'h22) ? v - 8'd1 : v;
                    res.code = ((w - 8'h0a) >> 1) + base + 8'h16;
                end
            end
            else if (v >= 8'h29 && v <= 8'h2d) begin
                res.code = (v - 8'h29) + base + 8'h25;
            end
            else if (v >= 8'h3d && v <= 8'h41) begin
                res.code = (v - 8'h3d) + base + 8'h2f;
            end
            else if (v >= 8'h49 && v <= 8'h4d) begin
                res.code = (v - 8'h49) + base + 8'h37;
            end
            else if (v >= 8'h2e && v <= 8'h3c) begin
                res.code = div3_small(v - 8'h2e) + base + 8'h2a;
            end
            else if (v >= 8'h42 && v <= 8'h48) begin
                res.code = (v >> 1) + base + (v[0] ? 8'h34 : 8'h0d) - 8'h21;
            end
            else if (v == 8'h4e) begin
                res.code = base + 8'h3c;
            end
            else if (v == 8'h52) begin
                res.code = base + 8'h3d;
            end
            else if (v == 8'h51) begin
                res.code = base + 8'h06;
            end
            else begin
                res.valid = 1'b0;
            end
            return res;
        end
    endfunction

    function automatic tile_t pair_tile(input logic [7:0] lead, input logic [7:0] t);
        tile_t res;
        begin
            res.valid = 1'b0;
            res.code  = 8'd0;
            if (lead == LEAD_HIRA && t >= 8'h9f && t <= 8'hf1)
                res = kana_tile(t, 1'b1);
            else if (lead == LEAD_KATA && t >= 8'h40 && t <= 8'h96)
                res = kana_tile(t, 1'b0);
            else if (lead == LEAD_YEN && t == TRAIL_YEN) begin
                res.valid = 1'b1;
                res.code  = TILE_YEN;
            end
            return res;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sjis_kana_to_tile_code_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_kana_to_tile_code_top
// Shift-JIS kana byte stream to 8-bit tile code converter.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue is not full. A classifier
// maps ASCII, hiragana, katakana and the yen kanji pair in the accepting
// cycle and writes at most one result word into a two-entry queue; the
// output register drains the queue one word per cycle, so with the sink
// ready the sustained rate is one byte per clock. Newlines and lead bytes
// give no word. After an error word the block ignores all input until
// reset.
module sjis_kana_to_tile_code_top
    import sktc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // in_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // code[7:0], error_pos[23:8]
    output logic [1:0]       m_tuser     // status[1:0]
);

    logic    q_full;
    logic    push;
    result_t push_data;
    logic    q_valid;
    result_t q_data;
    logic    q_pop;

    sktc_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    sktc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (q_pop)
    );

    sktc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/sktc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktc_front
// Accepts input bytes, tracks lead byte, position and halt, and classifies
// each byte into at most one result word for the queue.
// ----------------------------------------------------------------------------
module sktc_front
    import sktc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // in_byte[7:0]
    input  wire logic       q_full,
    output logic            push,
    output result_t         push_data
);

    logic                lead_pending_reg, lead_pending_next;
    logic [7:0]          lead_byte_reg, lead_byte_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                halted_reg, halted_next;

    logic                accept;
    logic [7:0]          b;
    logic [POS_BITS+15:0] pos_ext;
    tile_t               pt;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign pos_ext  = {16'd0, pos_reg};
    assign pt       = pair_tile(lead_byte_reg, b);

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        pos_next          = pos_reg;
        halted_next       = halted_reg;
        push              = 1'b0;
        push_data.code      = 8'd0;
        push_data.status    = ST_CHAR;
        push_data.error_pos = 16'd0;
        if (accept && !halted_reg) begin
            if (lead_pending_reg) begin
                lead_pending_next = 1'b0;
                push = 1'b1;
                if (pt.valid) begin
                    pos_next       = pos_reg + 1'b1;
                    push_data.code = pt.code;
                end
                else begin
                    halted_next         = 1'b1;
                    push_data.status    = ST_ERR;
                    push_data.error_pos = pos_ext[15:0];
                end
            end
            else if (b == 8'h00) begin
                pos_next         = '0;
                push             = 1'b1;
                push_data.status = ST_END;
            end
            else if (b == 8'h0a) begin
                pos_next = pos_reg + 1'b1;
            end
            else if (b >= 8'h20 && b <= 8'h7d) begin
                pos_next       = pos_reg + 1'b1;
                push           = 1'b1;
                push_data.code = b - 8'h20;
            end
            else if (b >= 8'h81 && b <= 8'h9f) begin
                lead_pending_next = 1'b1;
                lead_byte_next    = b;
                pos_next          = pos_reg + 1'b1;
            end
            else begin
                halted_next         = 1'b1;
                push                = 1'b1;
                push_data.status    = ST_ERR;
                push_data.error_pos = pos_ext[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'd0;
            pos_reg          <= '0;
            halted_reg       <= 1'b0;
        end
        else begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            pos_reg          <= pos_next;
            halted_reg       <= halted_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sktc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktc_queue
// Short FIFO of result words between the classifier and the output stage.
// ----------------------------------------------------------------------------
module sktc_queue
    import sktc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         q_valid,
    output result_t      q_data,
    input  wire logic    pop
);

    result_t                entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg, count_next;
    logic                   do_push, do_pop;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] r;
        begin
            if (p == QPTR_BITS'(QUEUE_DEPTH - 1))
                r = '0;
            else
                r = p + 1'b1;
            return r;
        end
    endfunction

    assign full    = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== rtl/sktc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktc_back
// Output stage: pulls result words from the queue into the output register
// and presents them on the master stream.
// ----------------------------------------------------------------------------
module sktc_back
    import sktc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire result_t     q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // code[7:0], error_pos[23:8]
    output logic [1:0]       m_tuser     // status[1:0]
);

    logic       valid_reg, valid_next;
    result_t    data_reg;
    logic       load;

    assign load       = q_valid && (!valid_reg || m_tready);
    assign q_pop      = load;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.error_pos, data_reg.code};
    assign m_tuser  = data_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= q_data;
    end

endmodule
`default_nettype wire

// ===== bench/tb_sjis_kana_to_tile_code_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sjis_kana_to_tile_code_top
// Self-checking bench for the Shift-JIS kana to tile code converter. A
// scoreboard predicts each result word from the bytes that go in (ASCII,
// newlines, hiragana, katakana, yen pair, terminators) and checks the output
// stream in order. Random idles on both sides. A longer final string is
// followed by an error and then by bytes that must be ignored.
// ----------------------------------------------------------------------------
module tb_sjis_kana_to_tile_code_top;
    import sktc_pkg::*;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] ASCII_LO   = 8'h20;
    localparam logic [7:0] ASCII_HI   = 8'h7d;
    localparam logic [7:0] LEAD_LO    = 8'h81;
    localparam logic [7:0] LEAD_HI    = 8'h9f;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         RANDOM_BYTES   = 600;

    class tile_scoreboard;
        bit        lead_held;
        bit [7:0]  lead_val;
        bit [15:0] offset;
        bit        stopped;
        result_t   expected_words[$];
        int        mismatches;

        function int kana_code(bit [7:0] t, bit hira);
            int       b;
            bit [7:0] tt;
            bit [7:0] v;
            bit [7:0] w;
            b  = hira ? 'hc0 : 'h80;
            tt = (t >= 8'h7f && t <= 8'h96) ? t - 8'd1 : t;
            v  = tt - (hira ? 8'h9f : 8'h40);
            if (v <= 8'h09)
                return v / 2 + b + (v[0] ? 'h11 : 'h07);
            if (v >= 8'h0a && v <= 8'h28)
            begin
                if (v == 8'h22)
                    return b + 'h0f;
                w = (v > 8'h22) ? v - 8'd1 : v;
                return (w - 'h0a) / 2 + b + 'h16;
            end
            if (v >= 8'h29 && v <= 8'h2d)
                return v - 'h29 + b + 'h25;
            if (v >= 8'h3d && v <= 8'h41)
                return v - 'h3d + b + 'h2f;
            if (v >= 8'h49 && v <= 8'h4d)
                return v - 'h49 + b + 'h37;
            if (v >= 8'h2e && v <= 8'h3c)
                return (v - 'h2e) / 3 + b + 'h2a;
            if (v >= 8'h42 && v <= 8'h48)
                return v / 2 + b + (v[0] ? 'h34 : 'h0d) - 'h21;
            if (v == 8'h4e)
                return b + 'h3c;
            if (v == 8'h52)
                return b + 'h3d;
            if (v == 8'h51)
                return b + 'h06;
            return -1;
        endfunction

        function int pair_code(bit [7:0] lead, bit [7:0] t);
            if (lead == LEAD_HIRA && t >= 8'h9f && t <= 8'hf1)
                return kana_code(t, 1'b1);
            if (lead == LEAD_KATA && t >= 8'h40 && t <= 8'h96)
                return kana_code(t, 1'b0);
            if (lead == LEAD_YEN && t == TRAIL_YEN)
                return TILE_YEN;
            return -1;
        endfunction

        function void add_word(bit [7:0] code, status_t st, bit [15:0] pos);
            result_t w;
            w.code      = code;
            w.status    = st;
            w.error_pos = pos;
            expected_words.push_back(w);
        endfunction

        function void note_byte(bit [7:0] b);
            int c;
            if (stopped)
                return;
            if (lead_held)
            begin
                lead_held = 1'b0;
                c = pair_code(lead_val, b);
                if (c < 0)
                begin
                    stopped = 1'b1;
                    add_word(8'h00, ST_ERR, offset);
                end
                else
                begin
                    offset++;
                    add_word(c[7:0], ST_CHAR, 16'h0);
                end
                return;
            end
            if (b == BYTE_NUL)
            begin
                offset = 16'h0;
                add_word(8'h00, ST_END, 16'h0);
            end
            else if (b == BYTE_LF)
                offset++;
            else if (b >= ASCII_LO && b <= ASCII_HI)
            begin
                offset++;
                add_word(b - ASCII_LO, ST_CHAR, 16'h0);
            end
            else if (b >= LEAD_LO && b <= LEAD_HI)
            begin
                lead_val  = b;
                lead_held = 1'b1;
                offset++;
            end
            else
            begin
                stopped = 1'b1;
                add_word(8'h00, ST_ERR, offset);
            end
        endfunction

        function void check_word(logic [7:0] code, logic [1:0] st, logic [15:0] pos);
            result_t w;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word code %h status %0d pos %h",
                         $time, code, st, pos);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            if (code !== w.code)
            begin
                $display("%0t: code mismatch exp %h got %h", $time, w.code, code);
                mismatches++;
            end
            if (st !== w.status)
            begin
                $display("%0t: status mismatch exp %0d got %0d", $time, w.status, st);
                mismatches++;
            end
            if (pos !== w.error_pos)
            begin
                $display("%0t: error_pos mismatch exp %h got %h", $time, w.error_pos, pos);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    tile_scoreboard board = new();
    int idle_mode = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    sjis_kana_to_tile_code_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink: check accepted words, then pick next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata[7:0], m_tuser, m_tdata[23:8]);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_mode == 1 || $urandom_range(0, 99) < 65)
            m_tready <= 1'b1;
        else
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 1)
            return 0;
        if (idle_mode == 2)
            return (r < 35) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(8, 40);
        return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_byte(b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_words.size() > 0);
    endtask

    task automatic send_kana(input logic [7:0] lead, input logic [7:0] lo,
                             input logic [7:0] hi);
        logic [7:0] t;
        do
            t = $urandom_range(lo, hi);
        while (board.pair_code(lead, t) < 0);
        send_byte(lead);
        send_byte(t);
    endtask

    task automatic send_error();
        logic [7:0] b;
        logic [7:0] t;
        case ($urandom_range(0, 5))
            0:
            begin
                do
                    b = $urandom_range(0, 255);
                while (b == BYTE_NUL || b == BYTE_LF || (b >= ASCII_LO && b <= ASCII_HI)
                       || (b >= LEAD_LO && b <= LEAD_HI));
                send_byte(b);
            end
            1:
            begin
                do
                    b = $urandom_range(LEAD_LO, LEAD_HI);
                while (b == LEAD_HIRA || b == LEAD_KATA || b == LEAD_YEN);
                send_byte(b);
                send_byte($urandom_range(0, 255));
            end
            2, 3:
            begin
                b = ($urandom_range(0, 1) == 0) ? LEAD_HIRA : LEAD_KATA;
                do
                    t = $urandom_range(0, 255);
                while (board.pair_code(b, t) >= 0);
                send_byte(b);
                send_byte(t);
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0: send_byte(LEAD_HIRA);
                    1: send_byte(LEAD_KATA);
                    default: send_byte(LEAD_YEN);
                endcase
                send_byte(BYTE_NUL);
            end
            default:
            begin
                do
                    t = $urandom_range(0, 255);
                while (t == TRAIL_YEN);
                send_byte(LEAD_YEN);
                send_byte(t);
            end
        endcase
    endtask

    initial
    begin
        int sent;
        int r;
        int n;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ASCII bounds, newline, kana edges, small tsu, voiced, yen
        send_byte(ASCII_LO);
        send_byte(ASCII_HI);
        send_byte(BYTE_LF);
        send_byte(8'h41);
        send_byte(LEAD_HIRA); send_byte(8'h9f);
        send_byte(LEAD_HIRA); send_byte(8'hf1);
        send_byte(LEAD_HIRA); send_byte(8'hc1);
        send_byte(LEAD_HIRA); send_byte(8'haa);
        send_byte(LEAD_HIRA); send_byte(8'hf0);
        send_byte(LEAD_KATA); send_byte(8'h40);
        send_byte(LEAD_KATA); send_byte(8'h7f);
        send_byte(LEAD_KATA); send_byte(8'h93);
        send_byte(LEAD_YEN);  send_byte(TRAIL_YEN);
        send_byte(BYTE_NUL);
        send_byte(BYTE_NUL);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (sent % 40 == 0)
                idle_mode = $urandom_range(0, 2);
            if (sent % 250 == 249)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                send_byte($urandom_range(ASCII_LO, ASCII_HI));
                sent++;
            end
            else if (r < 48)
            begin
                send_byte(BYTE_LF);
                sent++;
            end
            else if (r < 63)
            begin
                send_kana(LEAD_HIRA, 8'h9f, 8'hf1);
                sent += 2;
            end
            else if (r < 78)
            begin
                send_kana(LEAD_KATA, 8'h40, 8'h96);
                sent += 2;
            end
            else if (r < 82)
            begin
                send_byte(LEAD_YEN);
                send_byte(TRAIL_YEN);
                sent += 2;
            end
            else if (r < 90)
            begin
                send_byte(BYTE_NUL);
                sent++;
            end
            else
            begin
                send_byte(($urandom_range(0, 1) == 0) ? ASCII_LO : ASCII_HI);
                sent++;
            end
        end

        // longer string, then an error
        idle_mode = 0;
        send_byte(BYTE_NUL);
        n = $urandom_range(80, 140);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 85)
                send_byte(BYTE_LF);
            else
                send_byte($urandom_range(ASCII_LO, ASCII_HI));
        end
        send_error();

        // halted: all of these are dropped
        send_byte(8'h41);
        send_byte(BYTE_NUL);
        send_byte(LEAD_HIRA);
        send_byte(8'h9f);
        send_byte(8'hff);
        wait_drained();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
